@@ design/isolated_pixel_counter_macros.svh @@
// ----------------------------------------------------------------------------
// isolated_pixel_counter_macros.svh
// Assertion macros used by the isolated pixel counter RTL.
// ----------------------------------------------------------------------------
`ifndef ISOLATED_PIXEL_COUNTER_MACROS_SVH
`define ISOLATED_PIXEL_COUNTER_MACROS_SVH

// Checked on every clock edge, off while reset is high
`define IPC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included
`define IPC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/ipc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipc_pkg
// Types and constants of the isolated pixel counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

   // Default line store depth and frame height limit
   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 128;

   // Field widths
   localparam int CELL_W  = 8;
   localparam int CFG_W   = 8;
   localparam int COUNT_W = 15;
   localparam int ADD_W   = 3;

   // Character that marks a set cell
   localparam logic [CELL_W-1:0] SET_CHAR = 8'd42;

   // Saturation point of the count
   localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

   // Register index (byte address bit 2)
   localparam logic REG_FRAME_ROWS = 1'b0;
   localparam logic REG_FRAME_COLS = 1'b1;

   // One column of the window: [2] two rows up, [1] previous row, [0] current row
   typedef logic [2:0] ipc_col_type;

   // Position of the cell in the evaluation stage
   typedef struct packed {
      logic last_col;
      logic last_row;
   } ipc_flags_type;

endpackage

`default_nettype wire

@@ design/isolated_pixel_counter.sv @@
// ----------------------------------------------------------------------------
// isolated_pixel_counter
// Counts the set cells of a raster frame that have no set 8-neighbour.
// ----------------------------------------------------------------------------
// Cells stream in raster order, one per clock, with no gap needed between
// them. Frame totals go into a two-entry result buffer, so even one-cell
// frames keep that rate while the result channel takes one transaction per
// cycle. Only the last cell of a frame can wait, and only while both buffer
// entries would still be full on the cycle its total arrives.
// Each cell reads its column of the two-row line store (one synchronous
// memory, one read and one write port) at acceptance; in the cycle after
// that, the entry is written back shifted and a 3x3 window settles the
// cells it closes. The frame total passes through the evaluation stage
// into the head entry of the result buffer, which drives the result port,
// when no earlier total is still waiting. No clearing pass is needed after
// reset or a register write: rows that do not exist yet are masked by the
// row position. Writing frame_rows or frame_cols restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module isolated_pixel_counter #(
   parameter int MAX_COLS = ipc_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = ipc_pkg::DEF_MAX_ROWS
) (
   input  wire                          clock,
   input  wire                          reset,
   // input cells
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [ipc_pkg::CELL_W-1:0]    req_cell_byte,
   // frame results
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [ipc_pkg::COUNT_W-1:0]  rsp_isolated_count,
   // register port
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [2:0]                    paddr,
   input  wire [31:0]                   pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import ipc_pkg::*;

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // Registers
   logic [CFG_W-1:0]   rows_ff, rows_in;
   logic [CFG_W-1:0]   cols_ff, cols_in;
   logic               cfg_write;

   // Position of the next cell
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   cols_last;
   logic [ROW_W-1:0]   rows_last;
   logic               in_last_col;
   logic               in_last_row;
   logic               req_accept;

   // Evaluation stage
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_set_ff;
   logic [COL_W-1:0]   s1_col_ff;
   ipc_flags_type      s1_flags_ff;
   logic               s1_row_ge1_ff;
   logic               s1_row_ge2_ff;
   logic               s1_fwd_ff;
   logic [1:0]         s1_fwd_data_ff;
   logic               s1_frame_end;

   // Line store
   logic [1:0]         hist_mem [MAX_COLS];
   logic [1:0]         hist_rd_ff;
   logic [1:0]         hist_cur;
   logic [1:0]         hist_wr;

   // Window and count
   ipc_col_type        win_mid_ff, win_mid_in;
   ipc_col_type        win_left_ff, win_left_in;
   ipc_col_type        new_col;
   logic [ADD_W-1:0]   isolated_add;
   logic [COUNT_W:0]   count_sum;
   logic [COUNT_W-1:0] count_sat;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Result buffer: head entry and spare entry
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               spare_valid_ff, spare_valid_in;
   logic [COUNT_W-1:0] spare_count_ff, spare_count_in;
   logic               rsp_pop;

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (cfg_write) begin
         case (paddr[2])
            REG_FRAME_ROWS: rows_in = pwdata[CFG_W-1:0];
            REG_FRAME_COLS: cols_in = pwdata[CFG_W-1:0];
            default:        rows_in = rows_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FRAME_ROWS: prdata = 32'(rows_ff);
         REG_FRAME_COLS: prdata = 32'(cols_ff);
         default:        prdata = '0;
      endcase
   end

   // Effective last index: zero reads as one, large values clamp
   always_comb begin
      if (cols_ff == '0) begin
         cols_last = '0;
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_last = COL_W'(MAX_COLS - 1);
      end else begin
         cols_last = COL_W'(cols_ff - CFG_W'(1));
      end
      if (rows_ff == '0) begin
         rows_last = '0;
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_last = ROW_W'(MAX_ROWS - 1);
      end else begin
         rows_last = ROW_W'(rows_ff - CFG_W'(1));
      end
   end

   // ---------------------------------------------------------------------
   // Acceptance and raster position
   // ---------------------------------------------------------------------
   assign in_last_col   = (col_ff == cols_last);
   assign in_last_row   = (row_ff == rows_last);
   assign s1_frame_end  = s1_valid_ff & s1_flags_ff.last_col & s1_flags_ff.last_row;

   // Only a frame's last cell needs a free buffer entry in the cycle its total arrives
   assign req_ready  = ~(in_last_col & in_last_row & spare_valid_in);
   assign req_accept = req_valid & req_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (in_last_col) begin
            col_in = '0;
            row_in = in_last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign s1_valid_in = req_accept & ~cfg_write;

   // ---------------------------------------------------------------------
   // Line store: read at acceptance, write back from the evaluation stage
   // ---------------------------------------------------------------------
   assign hist_cur = s1_fwd_ff ? s1_fwd_data_ff : hist_rd_ff;
   assign hist_wr  = {hist_cur[0], s1_set_ff};

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         hist_mem[s1_col_ff] <= hist_wr;
      end
      if (req_accept) begin
         hist_rd_ff <= hist_mem[col_ff];
      end
   end

   // Stage payload; forward when the write hits the entry being read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_set_ff      <= (req_cell_byte == SET_CHAR);
         s1_col_ff      <= col_ff;
         s1_flags_ff    <= '{last_col: in_last_col, last_row: in_last_row};
         s1_row_ge1_ff  <= (row_ff != '0);
         s1_row_ge2_ff  <= (row_ff > ROW_W'(1));
         s1_fwd_ff      <= s1_valid_ff & (s1_col_ff == col_ff);
         s1_fwd_data_ff <= hist_wr;
      end
   end

   // ---------------------------------------------------------------------
   // Window and isolation test
   // ---------------------------------------------------------------------
   assign new_col = {hist_cur[1] & s1_row_ge2_ff, hist_cur[0] & s1_row_ge1_ff, s1_set_ff};

   ipc_eval u_eval (
      .left_col     (win_left_ff),
      .mid_col      (win_mid_ff),
      .new_col      (new_col),
      .flags        (s1_flags_ff),
      .isolated_add (isolated_add)
   );

   // Window clears at the end of each row and on a register write, so column zero sees a clear edge
   always_comb begin
      win_mid_in  = win_mid_ff;
      win_left_in = win_left_ff;
      if (cfg_write) begin
         win_mid_in  = '0;
         win_left_in = '0;
      end else if (s1_valid_ff) begin
         if (s1_flags_ff.last_col) begin
            win_mid_in  = '0;
            win_left_in = '0;
         end else begin
            win_mid_in  = new_col;
            win_left_in = win_mid_ff;
         end
      end
   end

   // Running count, saturating
   assign count_sum = {1'b0, count_ff} + (COUNT_W+1)'(isolated_add);
   assign count_sat = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (cfg_write || s1_frame_end) begin
         count_in = '0;
      end else if (s1_valid_ff) begin
         count_in = count_sat;
      end
   end

   // ---------------------------------------------------------------------
   // Result buffer: the head drives the port, the spare catches a total
   // that arrives while the head still waits
   // ---------------------------------------------------------------------
   assign rsp_pop = rsp_valid_ff & rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_count_in   = rsp_count_ff;
      spare_valid_in = spare_valid_ff;
      spare_count_in = spare_count_ff;
      if (rsp_pop) begin
         rsp_valid_in   = spare_valid_ff;
         rsp_count_in   = spare_count_ff;
         spare_valid_in = 1'b0;
      end
      if (s1_frame_end) begin
         if (rsp_valid_in) begin
            spare_valid_in = 1'b1;
            spare_count_in = count_sat;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_count_in = count_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff   <= rsp_count_in;
      spare_count_ff <= spare_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_isolated_count = rsp_count_ff;

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff        <= CFG_W'(1);
         cols_ff        <= CFG_W'(1);
         col_ff         <= '0;
         row_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         win_mid_ff     <= '0;
         win_left_ff    <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         rows_ff        <= rows_in;
         cols_ff        <= cols_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         s1_valid_ff    <= s1_valid_in;
         win_mid_ff     <= win_mid_in;
         win_left_ff    <= win_left_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`include "isolated_pixel_counter_macros.svh"

   `IPC_ASSERT(a_result_origin, $rose(rsp_valid_ff) |-> $past(s1_frame_end), "stray result")
   `IPC_ASSERT(a_no_result_overwrite, s1_frame_end |-> !spare_valid_ff, "result buffer overflow")
   `IPC_ASSERT(a_spare_behind_head, spare_valid_ff |-> rsp_valid_ff, "spare without head")
   `IPC_ASSERT(a_count_cleared, s1_frame_end |=> (count_ff == '0), "count not cleared")
   `IPC_ASSERT(a_col_in_range, col_ff <= cols_last, "column position beyond frame width")
   `IPC_ASSERT_ALWAYS(a_pready_high, pready, "register port stalled")

endmodule

`default_nettype wire

@@ design/ipc_eval.sv @@
// ----------------------------------------------------------------------------
// ipc_eval
// Isolation test on a three-column window. Counts the isolated set cells
// that the newest column settles: the previous row and, in the last row of
// the frame, the current row; at the right edge also the newest column.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_eval (
   input  wire ipc_pkg::ipc_col_type    left_col,
   input  wire ipc_pkg::ipc_col_type    mid_col,
   input  wire ipc_pkg::ipc_col_type    new_col,
   input  wire ipc_pkg::ipc_flags_type  flags,
   output logic [ipc_pkg::ADD_W-1:0]    isolated_add
);
   import ipc_pkg::*;

   logic mid_row_left;
   logic mid_row_right;
   logic cur_row_left;
   logic cur_row_right;

   // Previous row, column one to the left of the newest
   assign mid_row_left = mid_col[1] & ~(|left_col) & ~mid_col[2] & ~mid_col[0]
                         & ~(|new_col);

   // Previous row, newest column, nothing to its right
   assign mid_row_right = flags.last_col & new_col[1] & ~(|mid_col)
                          & ~new_col[2] & ~new_col[0];

   // Last row: no row below it
   assign cur_row_left = flags.last_row & mid_col[0] & ~left_col[1] & ~left_col[0]
                         & ~mid_col[1] & ~new_col[1] & ~new_col[0];

   assign cur_row_right = flags.last_row & flags.last_col & new_col[0]
                          & ~mid_col[1] & ~mid_col[0] & ~new_col[1];

   assign isolated_add = ADD_W'(mid_row_left) + ADD_W'(mid_row_right)
                       + ADD_W'(cur_row_left) + ADD_W'(cur_row_right);

endmodule

`default_nettype wire

@@ dv/tb_isolated_pixel_counter.sv @@
// ----------------------------------------------------------------------------
// tb_isolated_pixel_counter
// Self-checking bench for the isolated pixel counter.
// ----------------------------------------------------------------------------
// A short table of hand-checked frames runs first: the 1x1 frame, zero sizes,
// corners, diagonal contact and a frame dropped by a register write. Random
// phases follow, each with its own frame size, set density and idle pattern.
// The extremes of both size registers are included. An in-bench raster
// model computes each frame total, and every transaction on the result
// channel is compared against it in order. One phase holds the result
// channel off for a long stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_isolated_pixel_counter;
   import ipc_pkg::*;

   localparam int          MAX_C         = DEF_MAX_COLS;
   localparam int          MAX_R         = DEF_MAX_ROWS;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          RANDOM_CELLS  = 530;
   localparam int          CYCLE_LIMIT   = 300000;
   localparam logic [7:0]  STAR          = SET_CHAR;
   localparam logic [7:0]  DOT           = 8'h2E;

   // Directed table: a cell, or a write of one size register
   typedef enum logic [1:0] {DO_CELL, SET_ROWS, SET_COLS} step_kind_type;

   typedef struct packed {
      step_kind_type       kind;
      logic [7:0]          value;
      logic                typed;
      logic [COUNT_W-1:0]  total;
   } dir_step_type;

   typedef struct packed {
      logic                typed;
      logic [COUNT_W-1:0]  total;
   } cell_note_type;

   localparam int N_DIR = 31;
   localparam dir_step_type DIR_STEPS [0:N_DIR-1] = '{
      // 1x1 frames after reset: only the set character counts
      '{DO_CELL,  STAR,  1'b1, 15'd1},
      '{DO_CELL,  8'h00, 1'b1, 15'd0},
      '{DO_CELL,  8'hFF, 1'b1, 15'd0},
      '{DO_CELL,  8'h2B, 1'b1, 15'd0},
      // zero sizes read as one
      '{SET_ROWS, 8'd0,  1'b0, 15'd0},
      '{SET_COLS, 8'd0,  1'b0, 15'd0},
      '{DO_CELL,  STAR,  1'b1, 15'd1},
      // 3x3 with the four corners set
      '{SET_ROWS, 8'd3,  1'b0, 15'd0},
      '{SET_COLS, 8'd3,  1'b0, 15'd0},
      '{DO_CELL,  STAR,  1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b0, 15'd0},
      '{DO_CELL,  STAR,  1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b0, 15'd0},
      '{DO_CELL,  STAR,  1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b0, 15'd0},
      '{DO_CELL,  STAR,  1'b1, 15'd4},
      // 2x2 diagonal pair touches
      '{SET_ROWS, 8'd2,  1'b0, 15'd0},
      '{SET_COLS, 8'd2,  1'b0, 15'd0},
      '{DO_CELL,  STAR,  1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b0, 15'd0},
      '{DO_CELL,  STAR,  1'b1, 15'd0},
      // half a frame, then dropped by a register write
      '{DO_CELL,  STAR,  1'b0, 15'd0},
      '{DO_CELL,  STAR,  1'b0, 15'd0},
      '{SET_COLS, 8'd2,  1'b0, 15'd0},
      '{DO_CELL,  STAR,  1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b0, 15'd0},
      '{DO_CELL,  DOT,   1'b1, 15'd1}
   };

   // DUT signals
   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [CELL_W-1:0]   req_cell_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [COUNT_W-1:0]  rsp_isolated_count;
   logic                psel          = 1'b0;
   logic                penable       = 1'b0;
   logic                pwrite        = 1'b0;
   logic [2:0]          paddr         = '0;
   logic [31:0]         pwdata        = '0;
   logic [31:0]         prdata;
   logic                pready;

   // Raster model state
   logic [1:0]          hist_bits [MAX_C];
   logic                cur_bits  [MAX_C];
   int unsigned         next_col;
   int unsigned         next_row;
   int unsigned         iso_tally;
   logic [7:0]          rows_reg = 8'd1;
   logic [7:0]          cols_reg = 8'd1;

   // Bench bookkeeping
   logic [COUNT_W-1:0]  frame_totals_q [$];
   cell_note_type       cell_notes_q [$];
   int                  n_errors  = 0;
   int                  cells_sent = 0;
   int                  cycle_count = 0;
   int                  star_pct  = 30;
   bit                  no_gaps   = 1'b0;
   int                  hold_reqs = 0;
   int                  holds_taken = 0;

   isolated_pixel_counter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cell_byte      (req_cell_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_isolated_count (rsp_isolated_count),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Raster model
   // ------------------------------------------------------------------------
   function automatic int unsigned frame_dim(input logic [7:0] v, input int unsigned lim);
      if (v == 8'd0) return 1;
      if (v > lim) return lim;
      return 32'(v);
   endfunction

   function automatic void clear_raster();
      int c;
      for (c = 0; c < MAX_C; c++) begin
         hist_bits[c] = 2'b00;
         cur_bits[c]  = 1'b0;
      end
      next_col  = 0;
      next_row  = 0;
      iso_tally = 0;
   endfunction

   // which: 0 = two rows up, 1 = middle row, 2 = row just completed
   function automatic bit cell_bit(input int which, input int c, input int unsigned ncols,
                                   input bit above, input bit below);
      if (c < 0 || c >= int'(ncols)) return 1'b0;
      case (which)
         0: return above ? hist_bits[c][1] : 1'b0;
         1: return hist_bits[c][0];
         default: return below ? cur_bits[c] : 1'b0;
      endcase
   endfunction

   // Isolated set cells of the middle row
   function automatic int unsigned row_isolated(input int unsigned ncols, input bit above,
                                                input bit below);
      int unsigned n;
      int c;
      bit nb;
      n = 0;
      for (c = 0; c < int'(ncols); c++) begin
         if (cell_bit(1, c, ncols, above, below)) begin
            nb = cell_bit(0, c-1, ncols, above, below) | cell_bit(0, c, ncols, above, below) |
                 cell_bit(0, c+1, ncols, above, below) | cell_bit(1, c-1, ncols, above, below) |
                 cell_bit(1, c+1, ncols, above, below) | cell_bit(2, c-1, ncols, above, below) |
                 cell_bit(2, c, ncols, above, below)   | cell_bit(2, c+1, ncols, above, below);
            if (!nb) n++;
         end
      end
      return n;
   endfunction

   function automatic void add_isolated(input int unsigned n);
      iso_tally = iso_tally + n;
      if (iso_tally > COUNT_MAX) iso_tally = 32'(COUNT_MAX);
   endfunction

   // Takes one cell; returns 1 with the frame total on the last cell
   function automatic bit absorb_cell(input logic [7:0] b, output logic [COUNT_W-1:0] total);
      int unsigned nrows;
      int unsigned ncols;
      int unsigned col;
      int c;
      nrows = frame_dim(rows_reg, MAX_R);
      ncols = frame_dim(cols_reg, MAX_C);
      total = '0;
      col   = next_col;
      if (col >= ncols) col = ncols - 1;
      cur_bits[col] = (b == STAR);
      if (col + 1 < ncols) begin
         next_col = col + 1;
         return 1'b0;
      end
      // row complete: the row above it is now settled
      if (next_row >= 1) add_isolated(row_isolated(ncols, next_row >= 2, 1'b1));
      for (c = 0; c < MAX_C; c++)
         hist_bits[c] = {hist_bits[c][0], cur_bits[c]};
      if (next_row + 1 >= nrows) begin
         // last row has nothing below it
         add_isolated(row_isolated(ncols, next_row >= 1, 1'b0));
         total = iso_tally[COUNT_W-1:0];
         clear_raster();
         return 1'b1;
      end
      for (c = 0; c < MAX_C; c++)
         cur_bits[c] = 1'b0;
      next_col = 0;
      next_row++;
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard: predict on input transactions, check result transactions
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cell_note_type       note;
      logic [COUNT_W-1:0]  total;
      logic [COUNT_W-1:0]  want;
      bit                  got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            note = '0;
            if (cell_notes_q.size() != 0) note = cell_notes_q.pop_front();
            got = absorb_cell(req_cell_byte, total);
            if (got) frame_totals_q.push_back(note.typed ? note.total : total);
            else if (note.typed) begin
               $error("directed table: frame did not end where a total was given");
               n_errors++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_totals_q.size() == 0) begin
               $error("isolated_count: no result expected, got %0d", rsp_isolated_count);
               n_errors++;
            end else begin
               want = frame_totals_q.pop_front();
               if (rsp_isolated_count !== want) begin
                  $error("isolated_count: expected %0d, actual %0d", want, rsp_isolated_count);
                  n_errors++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result channel: random back-pressure, plus one long hold on request
   // ------------------------------------------------------------------------
   initial begin
      int n;
      int r;
      while (reset) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (holds_taken != hold_reqs) begin
            n = HOLD_CYCLES;
            holds_taken++;
         end else if (r < 50) n = 0;
         else if (r < 90) n = $urandom_range(1, 3);
         else n = $urandom_range(8, 40);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 6)) @(posedge clock);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int send_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_cell();
      logic [7:0] b;
      if ($urandom_range(0, 99) < star_pct) return STAR;
      case ($urandom_range(0, 3))
         0, 1:    b = 8'($urandom_range(0, 255));
         2:       b = STAR ^ (8'd1 << $urandom_range(0, 7));
         default: b = DOT;
      endcase
      return b;
   endfunction

   // Offers one cell and returns at the edge where it is accepted
   task automatic put_cell(input logic [7:0] b, input logic typed,
                           input logic [COUNT_W-1:0] total);
      cell_note_type note;
      int gap;
      gap = send_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      note.typed = typed;
      note.total = total;
      cell_notes_q.push_back(note);
      req_valid     <= 1'b1;
      req_cell_byte <= b;
      do @(posedge clock); while (!req_ready);
      cells_sent++;
   endtask

   // Waits until every frame total is in, then lets the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (frame_totals_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write followed by a read back
   task automatic set_size(input logic idx, input logic [7:0] v);
      logic [31:0] noise;
      settle();
      noise = $urandom();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {noise[31:8], v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // a write restarts the frame
      if (idx == REG_FRAME_ROWS) rows_reg = v;
      else cols_reg = v;
      clear_raster();
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== v) begin
         $error("%s readback: expected %0d, actual %0d",
                (idx == REG_FRAME_ROWS) ? "frame_rows" : "frame_cols", v, prdata[7:0]);
         n_errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // One random phase: new size, whole frames, maybe a trailing partial frame
   task automatic run_phase(input logic [7:0] rv, input logic [7:0] cv, input logic [1:0] mask,
                            input int frames, input bit partial, input bit hold);
      int unsigned n;
      if (mask[0]) set_size(REG_FRAME_ROWS, rv);
      if (mask[1]) set_size(REG_FRAME_COLS, cv);
      if (hold) begin
         // the long result stall is under way before the first cell goes out
         hold_reqs++;
         while (holds_taken != hold_reqs) @(posedge clock);
      end
      n = frame_dim(rows_reg, MAX_R) * frame_dim(cols_reg, MAX_C);
      repeat (frames * n)
         if (cells_sent < RANDOM_CELLS) put_cell(rand_cell(), 1'b0, '0);
      if (partial && n > 1)
         repeat ($urandom_range(1, n - 1))
            if (cells_sent < RANDOM_CELLS) put_cell(rand_cell(), 1'b0, '0);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int          i;
      int          phase;
      int          r;
      int          frames;
      bit          partial;
      bit          hold;
      logic [7:0]  rv;
      logic [7:0]  cv;
      logic [1:0]  mask;
      clear_raster();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (i = 0; i < N_DIR; i++) begin
         case (DIR_STEPS[i].kind)
            SET_ROWS: set_size(REG_FRAME_ROWS, DIR_STEPS[i].value);
            SET_COLS: set_size(REG_FRAME_COLS, DIR_STEPS[i].value);
            default:  put_cell(DIR_STEPS[i].value, DIR_STEPS[i].typed, DIR_STEPS[i].total);
         endcase
      end

      // random phases
      cells_sent = 0;
      phase = 0;
      while (cells_sent < RANDOM_CELLS) begin
         star_pct = $urandom_range(3, 70);
         no_gaps  = ($urandom_range(0, 3) == 0);
         partial  = ($urandom_range(0, 2) == 0);
         hold     = 1'b0;
         mask     = 2'b11;
         frames   = 1;
         case (phase)
            0: begin
               rv = 8'd128;
               cv = 8'd1;
            end
            1: begin
               rv = 8'd1;
               cv = 8'd255;
            end
            2: begin
               // long result stall while 1x1 frames keep coming
               rv = 8'd1;
               cv = 8'd1;
               frames  = 40;
               partial = 1'b0;
               no_gaps = 1'b1;
               hold    = 1'b1;
            end
            default: begin
               r = $urandom_range(0, 99);
               if (r < 4) begin
                  rv = 8'($urandom_range(128, 255));
                  cv = 8'($urandom_range(1, 2));
               end else if (r < 8) begin
                  rv = 8'($urandom_range(1, 2));
                  cv = 8'($urandom_range(128, 255));
               end else if (r < 16) begin
                  rv = 8'($urandom_range(0, 2));
                  cv = 8'($urandom_range(0, 3));
                  frames = $urandom_range(1, 4);
               end else begin
                  rv = 8'($urandom_range(1, 6));
                  cv = 8'($urandom_range(1, 6));
                  frames = $urandom_range(1, 4);
                  r = $urandom_range(0, 9);
                  if (r == 0 && frame_dim(cols_reg, MAX_C) <= 8) mask = 2'b01;
                  if (r == 1 && frame_dim(rows_reg, MAX_R) <= 8) mask = 2'b10;
               end
            end
         endcase
         run_phase(rv, cv, mask, frames, partial, hold);
         phase++;
      end

      settle();
      if (n_errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/ipc_pkg.sv
design/ipc_eval.sv
design/isolated_pixel_counter.sv
dv/tb_isolated_pixel_counter.sv
